FILE: rtl/core/ssid_pkg.sv
// ----------------------------------------------------------------------------
// ssid_pkg: shared types and constants
// Sizes, event keys and cell control for the segment intersection sweep.
// ----------------------------------------------------------------------------
package ssid_pkg;

  localparam int SEG_MAX   = 64;
  localparam int IDX_W     = $clog2(SEG_MAX);
  localparam int CNT_W     = IDX_W + 1;
  localparam int EV_MAX    = 2 * SEG_MAX;
  localparam int EV_W      = IDX_W + 1;
  localparam int EVL_W     = EV_W + 1;
  localparam int CRD_W     = 16;
  localparam int TAG_W     = 16;
  // key: x (biased), end flag, y (biased), event code
  localparam int KEY_W     = 2 * CRD_W + 1 + EV_W;
  localparam int DRAIN_CYC = 2 * EV_MAX;
  localparam int DRN_W     = $clog2(DRAIN_CYC);

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] ax;
    logic signed [CRD_W-1:0] ay;
    logic signed [CRD_W-1:0] bx;
    logic signed [CRD_W-1:0] by;
    logic [TAG_W-1:0]        tag;
  } seg_t;

  typedef enum logic [1:0] {
    SO_HOLD,
    SO_SORT,
    SO_SHIFT,
    SO_CLR
  } sort_op_e;

  typedef enum logic [1:0] {
    LO_HOLD,
    LO_ROT,
    LO_REM,
    LO_INS
  } list_op_e;

  typedef struct packed {
    list_op_e         op;
    logic [IDX_W-1:0] head_idx;
    logic [IDX_W-1:0] new_idx;
  } list_ctl_t;

  typedef struct packed {
    logic in_rng;
    logic is_last;
    logic at_len;
  } cell_pos_t;

endpackage

FILE: rtl/core/ssid_sort_cell.sv
// ----------------------------------------------------------------------------
// ssid_sort_cell: one cell of the event sorting chain
// Keeps the smaller key, hands the larger one on; shifts toward the head.
// ----------------------------------------------------------------------------
module ssid_sort_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssid_pkg::sort_op_e op_i,
  input  logic              in_v_i,
  input  ssid_pkg::key_t    in_key_i,
  input  logic              rt_v_i,
  input  ssid_pkg::key_t    rt_key_i,
  output logic              hv_o,
  output ssid_pkg::key_t    hkey_o,
  output logic              pv_o,
  output ssid_pkg::key_t    pkey_o
);
  import ssid_pkg::*;

  logic hv_q, pv_q;
  key_t hkey_q, pkey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= 1'b0;
      pv_q <= 1'b0;
    end else begin
      case (op_i)
        SO_SORT: begin
          pv_q <= in_v_i & hv_q;
          if (in_v_i) begin
            if (!hv_q) begin
              hv_q <= 1'b1;
            end
          end
        end
        SO_SHIFT: begin
          hv_q <= rt_v_i;
          pv_q <= 1'b0;
        end
        SO_CLR: begin
          hv_q <= 1'b0;
          pv_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      SO_SORT: begin
        if (in_v_i) begin
          if (!hv_q || (in_key_i < hkey_q)) begin
            hkey_q <= in_key_i;
            pkey_q <= hkey_q;
          end else begin
            pkey_q <= in_key_i;
          end
        end
      end
      SO_SHIFT: hkey_q <= rt_key_i;
      default: ;
    endcase
  end

  assign hv_o   = hv_q;
  assign hkey_o = hkey_q;
  assign pv_o   = pv_q;
  assign pkey_o = pkey_q;

endmodule

FILE: rtl/core/ssid_list_cell.sv
// ----------------------------------------------------------------------------
// ssid_list_cell: one cell of the active segment ring
// Holds one segment index; rotates, closes a gap or takes a new index.
// ----------------------------------------------------------------------------
module ssid_list_cell (
  input  logic                         clk_i,
  input  ssid_pkg::list_ctl_t          ctl_i,
  input  ssid_pkg::cell_pos_t          pos_i,
  input  logic [ssid_pkg::IDX_W-1:0]   right_i,
  output logic [ssid_pkg::IDX_W-1:0]   idx_o
);
  import ssid_pkg::*;

  logic [IDX_W-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      LO_ROT: begin
        if (pos_i.in_rng) begin
          idx_q <= pos_i.is_last ? ctl_i.head_idx : right_i;
        end
      end
      LO_REM: idx_q <= right_i;
      LO_INS: begin
        if (pos_i.at_len) begin
          idx_q <= ctl_i.new_idx;
        end
      end
      default: ;
    endcase
  end

  assign idx_o = idx_q;

endmodule

FILE: rtl/core/ssid_geom.sv
// ----------------------------------------------------------------------------
// ssid_geom: two-stage segment pair test
// Stage 1 forms the cross-product terms, stage 2 gives meet and below flags.
// ----------------------------------------------------------------------------
module ssid_geom (
  input  logic           clk_i,
  input  ssid_pkg::seg_t p_i,
  input  ssid_pkg::seg_t q_i,
  output logic           meet_o,
  output logic           below_o
);
  import ssid_pkg::*;

  localparam int DW = CRD_W + 1;
  localparam int MW = 2 * DW;
  localparam int TW = MW + 1;

  function automatic logic signed [DW-1:0] dif(input logic signed [CRD_W-1:0] a,
                                               input logic signed [CRD_W-1:0] b);
    dif = DW'(a) - DW'(b);
  endfunction

  logic signed [MW-1:0] m_q [8];
  logic box_ok_q, ax_lt_q, ay_lt_q;
  logic meet_q, below_q;

  logic signed [CRD_W-1:0] p_ymax, p_ymin, q_ymax, q_ymin;
  logic signed [TW-1:0] z1, z2, z3, z4;
  logic n1, n2, n3, n4, s1, s2, s3, s4;

  always_comb begin
    p_ymax = (p_i.ay > p_i.by) ? p_i.ay : p_i.by;
    p_ymin = (p_i.ay > p_i.by) ? p_i.by : p_i.ay;
    q_ymax = (q_i.ay > q_i.by) ? q_i.ay : q_i.by;
    q_ymin = (q_i.ay > q_i.by) ? q_i.by : q_i.ay;
  end

  always_ff @(posedge clk_i) begin
    // turn(a,b,c) = (bx-ax)*(cy-ay) - (by-ay)*(cx-ax)
    m_q[0] <= dif(p_i.bx, p_i.ax) * dif(q_i.ay, p_i.ay);
    m_q[1] <= dif(p_i.by, p_i.ay) * dif(q_i.ax, p_i.ax);
    m_q[2] <= dif(p_i.bx, p_i.ax) * dif(q_i.by, p_i.ay);
    m_q[3] <= dif(p_i.by, p_i.ay) * dif(q_i.bx, p_i.ax);
    m_q[4] <= dif(q_i.bx, q_i.ax) * dif(p_i.ay, q_i.ay);
    m_q[5] <= dif(q_i.by, q_i.ay) * dif(p_i.ax, q_i.ax);
    m_q[6] <= dif(q_i.bx, q_i.ax) * dif(p_i.by, q_i.ay);
    m_q[7] <= dif(q_i.by, q_i.ay) * dif(p_i.bx, q_i.ax);
    // x endpoints are already ordered, so ax is the minimum
    box_ok_q <= !((p_i.bx < q_i.ax) || (q_i.bx < p_i.ax) ||
                  (p_ymax < q_ymin) || (q_ymax < p_ymin));
    ax_lt_q  <= p_i.ax < q_i.ax;
    ay_lt_q  <= p_i.ay < q_i.ay;
  end

  always_comb begin
    z1 = TW'(m_q[0]) - TW'(m_q[1]);
    z2 = TW'(m_q[2]) - TW'(m_q[3]);
    z3 = TW'(m_q[4]) - TW'(m_q[5]);
    z4 = TW'(m_q[6]) - TW'(m_q[7]);
    n1 = z1[TW-1];
    n2 = z2[TW-1];
    n3 = z3[TW-1];
    n4 = z4[TW-1];
    s1 = !n1 && (z1 != '0);
    s2 = !n2 && (z2 != '0);
    s3 = !n3 && (z3 != '0);
    s4 = !n4 && (z4 != '0);
  end

  always_ff @(posedge clk_i) begin
    meet_q  <= box_ok_q && !((n1 && n2) || (s1 && s2)) && !((n3 && n4) || (s3 && s4));
    below_q <= ax_lt_q ? (s1 || (!n1 && ay_lt_q)) : (n3 || (!s3 && ay_lt_q));
  end

  assign meet_o  = meet_q;
  assign below_o = below_q;

endmodule

FILE: rtl/core/segment_set_intersection_detect_unit.sv
// ----------------------------------------------------------------------------
// segment_set_intersection_detect_unit: sweep-line segment intersection test
// Loads a segment set, sorts its events in a cell chain and sweeps them
// through a ring of active-list cells, reporting the first meeting pair.
// ----------------------------------------------------------------------------
// Timing: each loaded segment puts a start and an end event into the sort
//   chain, and the input stalls while the end event is pending; after the
//   marked segment, a drain pass settles the sort chain. A start event
//   tests each list entry that it passes (memory read plus the
//   2-stage product unit), then laps back to the list head; an end event
//   walks the list to find its entry, then laps back the same way.
// Throughput: one set at a time; the next set loads after the result transfer.
// Reset: control, counts and valid flags clear; stores hold garbage until
//   written, no clearing pass.
module segment_set_intersection_detect_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,  // start_x, start_y, end_x, end_y, seg_tag
  input  logic        s_axis_tlast_i,  // last_segment
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // first_tag, second_tag
  output logic        m_axis_tuser_o   // found
);
  import ssid_pkg::*;

  typedef enum logic [3:0] {
    ST_LOAD, ST_DRAIN, ST_EV, ST_CUR, ST_SCAN, ST_RD, ST_G1, ST_G2, ST_CHK,
    ST_PREV, ST_INS, ST_ROT, ST_FIND, ST_LO, ST_LOQ, ST_REM
  } state_e;

  typedef enum logic [1:0] {
    CK_BELOW,
    CK_PREV,
    CK_PAIR
  } chk_e;

  state_e state_q;
  chk_e   op_q;
  logic   out_v_q;

  logic [CNT_W-1:0] cnt_q, len_q, lenold_q, rc_q;
  logic [EVL_W-1:0] evl_q;
  logic [DRN_W-1:0] drn_q;
  logic [IDX_W-1:0] cur_idx_q, prev_q;
  logic             cur_end_q;
  logic             endp_q, sin_v_q;
  key_t             endkey_q, sin_key_q;
  seg_t             p_q, q_q, rdata_q;
  logic             found_q;
  logic [TAG_W-1:0] ftag_q, stag_q;

  // segment memory
  seg_t             seg_mem [SEG_MAX];
  logic [IDX_W-1:0] raddr;

  // input unpack and endpoint ordering
  logic signed [CRD_W-1:0] x1, y1, x2, y2;
  seg_t  in_seg;
  logic  in_fire;
  logic [EV_W-2:0] ld_idx;

  assign x1 = s_axis_tdata_i[15:0];
  assign y1 = s_axis_tdata_i[31:16];
  assign x2 = s_axis_tdata_i[47:32];
  assign y2 = s_axis_tdata_i[63:48];
  assign ld_idx = cnt_q[IDX_W-1:0];

  always_comb begin
    if ((x1 > x2) || ((x1 == x2) && (y1 > y2))) begin
      in_seg.ax = x2; in_seg.ay = y2; in_seg.bx = x1; in_seg.by = y1;
    end else begin
      in_seg.ax = x1; in_seg.ay = y1; in_seg.bx = x2; in_seg.by = y2;
    end
    in_seg.tag = s_axis_tdata_i[79:64];
  end

  assign s_axis_tready_o = (state_q == ST_LOAD) && !endp_q && !out_v_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------- sort chain ----------------
  sort_op_e sort_op;
  logic     sc_hv [EV_MAX];
  key_t     sc_hk [EV_MAX];
  logic     sc_pv [EV_MAX];
  key_t     sc_pk [EV_MAX];
  logic [IDX_W-1:0] head_idx;
  logic             head_end;

  for (genvar i = 0; i < EV_MAX; i++) begin : g_sort
    logic in_v, rt_v;
    key_t in_k, rt_k;
    if (i == 0) begin : g_first
      assign in_v = sin_v_q;
      assign in_k = sin_key_q;
    end else begin : g_mid
      assign in_v = sc_pv[i-1];
      assign in_k = sc_pk[i-1];
    end
    if (i == EV_MAX - 1) begin : g_tail
      assign rt_v = 1'b0;
      assign rt_k = '0;
    end else begin : g_body
      assign rt_v = sc_hv[i+1];
      assign rt_k = sc_hk[i+1];
    end
    ssid_sort_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .op_i     (sort_op),
      .in_v_i   (in_v),
      .in_key_i (in_k),
      .rt_v_i   (rt_v),
      .rt_key_i (rt_k),
      .hv_o     (sc_hv[i]),
      .hkey_o   (sc_hk[i]),
      .pv_o     (sc_pv[i]),
      .pkey_o   (sc_pk[i])
    );
  end

  assign head_idx = sc_hk[0][EV_W-1:1];
  assign head_end = sc_hk[0][0];

  // ---------------- active ring ----------------
  list_ctl_t        lctl;
  logic [IDX_W-1:0] lc_idx [SEG_MAX];

  for (genvar i = 0; i < SEG_MAX; i++) begin : g_list
    cell_pos_t        pos;
    logic [IDX_W-1:0] rt;
    assign pos.in_rng  = CNT_W'(i) < len_q;
    assign pos.is_last = CNT_W'(i + 1) == len_q;
    assign pos.at_len  = CNT_W'(i) == len_q;
    if (i == SEG_MAX - 1) begin : g_tail
      assign rt = '0;
    end else begin : g_body
      assign rt = lc_idx[i+1];
    end
    ssid_list_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (lctl),
      .pos_i   (pos),
      .right_i (rt),
      .idx_o   (lc_idx[i])
    );
  end

  // ---------------- pair tester ----------------
  logic g_meet, g_below;

  ssid_geom u_geom (
    .clk_i   (clk_i),
    .p_i     (p_q),
    .q_i     (q_q),
    .meet_o  (g_meet),
    .below_o (g_below)
  );

  // ---------------- control ----------------
  always_comb begin
    sort_op       = SO_HOLD;
    lctl.op       = LO_HOLD;
    lctl.head_idx = lc_idx[0];
    lctl.new_idx  = cur_idx_q;
    raddr         = '0;
    case (state_q)
      ST_LOAD, ST_DRAIN: sort_op = SO_SORT;
      ST_EV: begin
        raddr = head_idx;
        if (evl_q != '0) sort_op = SO_SHIFT;
      end
      ST_SCAN: raddr = lc_idx[0];
      ST_PREV, ST_LO: raddr = prev_q;
      ST_LOQ: raddr = lc_idx[1];
      ST_CHK: begin
        if (op_q == CK_BELOW && g_below) lctl.op = LO_ROT;
      end
      ST_INS: lctl.op = LO_INS;
      ST_REM: lctl.op = LO_REM;
      ST_ROT: begin
        if (rc_q != lenold_q) lctl.op = LO_ROT;
      end
      ST_FIND: begin
        if (rc_q != lenold_q && lc_idx[0] != cur_idx_q) lctl.op = LO_ROT;
      end
      default: ;
    endcase
    // result taken: drop the sort chain contents for the next set
    if (out_v_q && m_axis_tready_i) sort_op = SO_CLR;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (cnt_q < CNT_W'(SEG_MAX))) begin
      seg_mem[ld_idx] <= in_seg;
    end
    rdata_q <= seg_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      out_v_q  <= 1'b0;
      cnt_q    <= '0;
      len_q    <= '0;
      endp_q   <= 1'b0;
      sin_v_q  <= 1'b0;
      drn_q    <= '0;
      evl_q    <= '0;
      rc_q     <= '0;
      lenold_q <= '0;
      op_q     <= CK_BELOW;
      found_q  <= 1'b0;
      ftag_q   <= '0;
      stag_q   <= '0;
    end else begin
      // end event follows its start event in the next cycle
      sin_v_q <= 1'b0;
      if (endp_q) begin
        sin_v_q   <= 1'b1;
        sin_key_q <= endkey_q;
        endp_q    <= 1'b0;
      end

      case (state_q)
        ST_LOAD: begin
          if (in_fire) begin
            if (cnt_q < CNT_W'(SEG_MAX)) begin
              sin_v_q   <= 1'b1;
              sin_key_q <= {~in_seg.ax[CRD_W-1], in_seg.ax[CRD_W-2:0], 1'b0,
                            ~in_seg.ay[CRD_W-1], in_seg.ay[CRD_W-2:0], ld_idx, 1'b0};
              endp_q    <= 1'b1;
              endkey_q  <= {~in_seg.bx[CRD_W-1], in_seg.bx[CRD_W-2:0], 1'b1,
                            ~in_seg.by[CRD_W-1], in_seg.by[CRD_W-2:0], ld_idx, 1'b1};
              cnt_q     <= cnt_q + 1'b1;
            end
            if (s_axis_tlast_i) begin
              drn_q   <= '0;
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          drn_q <= drn_q + 1'b1;
          if (drn_q == DRN_W'(DRAIN_CYC - 1)) begin
            evl_q   <= {cnt_q, 1'b0};
            len_q   <= '0;
            state_q <= ST_EV;
          end
        end
        ST_EV: begin
          if (evl_q == '0) begin
            found_q <= 1'b0;
            ftag_q  <= '0;
            stag_q  <= '0;
            out_v_q <= 1'b1;
            state_q <= ST_LOAD;
          end else begin
            evl_q     <= evl_q - 1'b1;
            cur_idx_q <= head_idx;
            cur_end_q <= head_end;
            state_q   <= ST_CUR;
          end
        end
        ST_CUR: begin
          q_q      <= rdata_q;
          rc_q     <= '0;
          lenold_q <= len_q;
          state_q  <= cur_end_q ? ST_FIND : ST_SCAN;
        end
        ST_SCAN: begin
          if (rc_q == lenold_q) begin
            state_q <= (rc_q != '0) ? ST_PREV : ST_INS;
          end else begin
            op_q    <= CK_BELOW;
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          p_q     <= rdata_q;
          state_q <= ST_G1;
        end
        ST_G1: state_q <= ST_G2;
        ST_G2: state_q <= ST_CHK;
        ST_CHK: begin
          case (op_q)
            CK_BELOW: begin
              if (g_below) begin
                prev_q  <= lc_idx[0];
                rc_q    <= rc_q + 1'b1;
                state_q <= ST_SCAN;
              end else if (g_meet) begin
                found_q <= 1'b1;
                ftag_q  <= p_q.tag;
                stag_q  <= q_q.tag;
                out_v_q <= 1'b1;
                state_q <= ST_LOAD;
              end else begin
                state_q <= (rc_q != '0) ? ST_PREV : ST_INS;
              end
            end
            CK_PREV, CK_PAIR: begin
              if (g_meet) begin
                found_q <= 1'b1;
                ftag_q  <= p_q.tag;
                stag_q  <= q_q.tag;
                out_v_q <= 1'b1;
                state_q <= ST_LOAD;
              end else begin
                state_q <= (op_q == CK_PREV) ? ST_INS : ST_REM;
              end
            end
            default: state_q <= ST_LOAD;
          endcase
        end
        ST_PREV: begin
          op_q    <= CK_PREV;
          state_q <= ST_RD;
        end
        ST_INS: begin
          len_q   <= len_q + 1'b1;
          state_q <= ST_ROT;
        end
        ST_ROT: begin
          // finish the lap so the list head is back in the first cell
          if (rc_q == lenold_q) begin
            state_q <= ST_EV;
          end else begin
            rc_q <= rc_q + 1'b1;
          end
        end
        ST_FIND: begin
          if (rc_q == lenold_q) begin
            state_q <= ST_EV;  // not in the list: event ignored
          end else if (lc_idx[0] == cur_idx_q) begin
            state_q <= ((rc_q != '0) && ((rc_q + 1'b1) < lenold_q)) ? ST_LO : ST_REM;
          end else begin
            prev_q <= lc_idx[0];
            rc_q   <= rc_q + 1'b1;
          end
        end
        ST_LO: state_q <= ST_LOQ;
        ST_LOQ: begin
          q_q     <= rdata_q;  // lower neighbor
          op_q    <= CK_PAIR;
          state_q <= ST_RD;    // upper neighbor read below
        end
        ST_REM: begin
          len_q   <= len_q - 1'b1;
          rc_q    <= rc_q + 1'b1;
          state_q <= ST_ROT;
        end
        default: state_q <= ST_LOAD;
      endcase

      if (out_v_q && m_axis_tready_i) begin
        out_v_q <= 1'b0;
        cnt_q   <= '0;
        len_q   <= '0;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {stag_q, ftag_q};
  assign m_axis_tuser_o  = found_q;

endmodule

FILE: verif/segment_set_intersection_detect_unit_tb.sv
// ----------------------------------------------------------------------------
// segment_set_intersection_detect_unit_tb: self-checking sweep testbench
// Streams segment sets into the unit, predicts each set's verdict with an
// in-bench sweep-line model and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module segment_set_intersection_detect_unit_tb;
  import ssid_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [79:0] s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  segment_set_intersection_detect_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  typedef struct {
    logic        found;
    logic [15:0] first_tag;
    logic [15:0] second_tag;
  } verdict_t;

  typedef struct {
    longint ax, ay, bx, by;
  } line_t;

  verdict_t verdict_q[$];
  line_t    set_seg[SEG_MAX];
  logic [15:0] set_tag[SEG_MAX];
  int       set_len = 0;
  int       err_cnt = 0;
  bit       quiet = 0;  // no idling at the end
  longint   cyc = 0;

  // --- sweep predictor ----------------------------------------------------
  function automatic longint cross3(longint ax, ay, bx, by, cx, cy);
    return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
  endfunction

  function automatic bit lies_below(line_t p, line_t q);
    longint s;
    if (p.ax < q.ax) begin
      s = cross3(p.ax, p.ay, p.bx, p.by, q.ax, q.ay);
      return s > 0 || (s == 0 && p.ay < q.ay);
    end
    s = cross3(q.ax, q.ay, q.bx, q.by, p.ax, p.ay);
    return s < 0 || (s == 0 && p.ay < q.ay);
  endfunction

  function automatic bit straddle(longint u, longint v);
    return !((u < 0 && v < 0) || (u > 0 && v > 0));
  endfunction

  function automatic longint mx(longint a, longint b); return a > b ? a : b; endfunction
  function automatic longint mn(longint a, longint b); return a < b ? a : b; endfunction

  function automatic bit lines_meet(line_t p, line_t q);
    if (mx(p.ax, p.bx) < mn(q.ax, q.bx) || mx(q.ax, q.bx) < mn(p.ax, p.bx) ||
        mx(p.ay, p.by) < mn(q.ay, q.by) || mx(q.ay, q.by) < mn(p.ay, p.by))
      return 0;
    if (!straddle(cross3(p.ax, p.ay, p.bx, p.by, q.ax, q.ay),
                  cross3(p.ax, p.ay, p.bx, p.by, q.bx, q.by)))
      return 0;
    return straddle(cross3(q.ax, q.ay, q.bx, q.by, p.ax, p.ay),
                    cross3(q.ax, q.ay, q.bx, q.by, p.bx, p.by));
  endfunction

  function automatic bit ev_earlier(int a, int b);
    longint xa, ya, xb, yb;
    xa = a[0] ? set_seg[a >> 1].bx : set_seg[a >> 1].ax;
    ya = a[0] ? set_seg[a >> 1].by : set_seg[a >> 1].ay;
    xb = b[0] ? set_seg[b >> 1].bx : set_seg[b >> 1].ax;
    yb = b[0] ? set_seg[b >> 1].by : set_seg[b >> 1].ay;
    if (xa != xb) return xa < xb;
    if (a[0] != b[0]) return a[0] == 0;
    return ya < yb;
  endfunction

  function automatic verdict_t sweep_set();
    verdict_t v;
    int evs[$];
    int act[$];
    int j, pos, s, e;
    v = '{1'b0, 16'h0, 16'h0};
    for (int i = 0; i < 2 * set_len; i++) begin
      j = evs.size();
      while (j > 0 && ev_earlier(i, evs[j-1])) j--;
      evs.insert(j, i);
    end
    foreach (evs[i]) begin
      e = evs[i];
      s = e >> 1;
      pos = 0;
      if (!e[0]) begin
        while (pos < act.size() && lies_below(set_seg[act[pos]], set_seg[s])) pos++;
        if (pos < act.size() && lines_meet(set_seg[act[pos]], set_seg[s]))
          return '{1'b1, set_tag[act[pos]], set_tag[s]};
        if (pos > 0 && lines_meet(set_seg[act[pos-1]], set_seg[s]))
          return '{1'b1, set_tag[act[pos-1]], set_tag[s]};
        act.insert(pos, s);
      end else begin
        while (pos < act.size() && act[pos] != s) pos++;
        if (pos >= act.size()) continue;
        if (pos > 0 && pos + 1 < act.size() &&
            lines_meet(set_seg[act[pos+1]], set_seg[act[pos-1]]))
          return '{1'b1, set_tag[act[pos+1]], set_tag[act[pos-1]]};
        act.delete(pos);
      end
    end
    return v;
  endfunction

  // --- sender -------------------------------------------------------------
  // tvalid stays high after a transfer; the next item or wait_drained moves it
  task automatic send_segment(logic signed [15:0] x1, y1, x2, y2,
                              logic [15:0] tag, bit last);
    line_t l;
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {tag, y2, x2, y1, x1};
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (set_len < SEG_MAX) begin
      if (x1 > x2 || (x1 == x2 && y1 > y2)) l = '{x2, y2, x1, y1};
      else l = '{x1, y1, x2, y2};
      set_seg[set_len] = l;
      set_tag[set_len] = tag;
      set_len++;
    end
    if (last) begin
      verdict_q.insert(verdict_q.size(), sweep_set());
      set_len = 0;
    end
  endtask

  // random set; small coordinate spans make crossings and ties common
  task automatic random_set(int n, int span);
    logic signed [15:0] c[4];
    for (int i = 0; i < n; i++) begin
      foreach (c[k])
        c[k] = (span >= 32768) ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
      send_segment(c[0], c[1], c[2], c[3], 16'($urandom), i == n - 1);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // --- result checker -----------------------------------------------------
  always @(posedge clk_i) begin
    verdict_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (verdict_q.size() == 0) begin
        $error("result transfer with nothing expected");
        err_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tuser_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, m_axis_tuser_o);
          err_cnt++;
        end
        if (m_axis_tdata_o[15:0] !== want.first_tag) begin
          $error("first_tag: expected %0h, got %0h", want.first_tag, m_axis_tdata_o[15:0]);
          err_cnt++;
        end
        if (m_axis_tdata_o[31:16] !== want.second_tag) begin
          $error("second_tag: expected %0h, got %0h", want.second_tag,
                 m_axis_tdata_o[31:16]);
          err_cnt++;
        end
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 16);
        m_axis_tready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > 64'd4000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --- tests --------------------------------------------------------------
  task automatic test_directed();
    // crossing X, then disjoint parallel pair
    send_segment(-10, -10, 10, 10, 16'h0001, 0);
    send_segment(-10, 10, 10, -10, 16'h0002, 1);
    send_segment(0, 0, 5, 0, 16'h0003, 0);
    send_segment(0, 3, 5, 3, 16'h0004, 1);
    // single segment set, a point segment
    send_segment(7, 7, 7, 7, 16'hFFFF, 1);
    // coordinate extremes, reversed endpoints
    send_segment(16'sh7FFF, 16'sh7FFF, -32768, -32768, 16'h8000, 0);
    send_segment(-32768, 16'sh7FFF, 16'sh7FFF, -32768, 16'h7FFF, 1);
    // collinear overlap and touching ends
    send_segment(0, 0, 4, 4, 16'h0010, 0);
    send_segment(2, 2, 6, 6, 16'h0011, 0);
    send_segment(6, 6, 9, 0, 16'h0012, 1);
    // vertical segments and exact ties
    send_segment(3, -5, 3, 5, 16'h0020, 0);
    send_segment(3, -5, 3, 5, 16'h0021, 1);
    // crossing pair with a short segment between; the pair meets at insertion
    send_segment(0, 0, 20, 10, 16'h0030, 0);
    send_segment(1, 5, 3, 5, 16'h0031, 0);
    send_segment(0, 10, 20, 0, 16'h0032, 1);
  endtask

  task automatic test_store_full();
    // overflow: 70 segments, the last six are dropped
    random_set(70, 3000);
  endtask

  task automatic test_random();
    int items = 0;
    int n;
    while (items < 1000) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0: random_set(n, 32768);
        1: random_set(n, 8);
        default: random_set(n, 200);
      endcase
      items += n;
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  task automatic test_tail();
    quiet = 1;
    random_set(10, 50);
    random_set(4, 4);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();  // sender holds until every verdict is back
    test_store_full();
    test_random();
    test_tail();
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
